### sv/gwp_pkg.sv
`timescale 1ns / 1ps
// Package for the gait waveform player: register indexes and reset values,
// the result record, output queue sizing and the cosine table generator.
// No dependencies.
package gwp_pkg;

  localparam int SAMPLES_DEFAULT = 300;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 12;

  localparam logic [CFG_IW-1:0] CFG_SPINE_MID  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SPINE_HALF = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_LEG_STEP   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_STEP_MS    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_UPDATE_MS  = 3'd4;

  localparam logic [11:0] SPINE_MID_RST  = 12'd2872;
  localparam logic [10:0] SPINE_HALF_RST = 11'd1158;
  localparam logic [7:0]  LEG_STEP_RST   = 8'd12;
  localparam logic [9:0]  STEP_MS_RST    = 10'd50;
  localparam logic [7:0]  UPDATE_MS_RST  = 8'd5;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic [8:0]         table_index;
    logic [11:0]        spine_q4;
    logic [15:0]        leg0_angle;
    logic [15:0]        leg1_angle;
    logic signed [15:0] rate_raw;
    logic signed [47:0] angle_accum;
  } gwp_result_t;

  typedef struct packed {
    logic               valid;
    logic [FIFO_CW-1:0] count;
  } gwp_fifo_stat_t;

  // Quarter-wave cosine in Q30 from a five-term polynomial, clamped at zero.
  function automatic logic [63:0] quarter_cos(logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] r;
    logic [63:0] p;
    u2 = (u * u) >> 30;
    r  = 64'd27060;
    r  = 64'd987048 - ((r * u2) >> 30);
    r  = 64'd22401993 - ((r * u2) >> 30);
    r  = 64'd272375614 - ((r * u2) >> 30);
    r  = 64'd1324675879 - ((r * u2) >> 30);
    p  = (r * u2) >> 30;
    return (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
  endfunction

  // Q1.15 cosine sample for a quadrant and a Q30 position within it.
  function automatic logic signed [15:0] cos_q15(logic [63:0] u_in, logic [1:0] quad);
    logic [63:0] u;
    logic [63:0] v;
    logic [15:0] mag;
    u   = quad[0] ? ONE_Q30 - u_in : u_in;
    v   = (quarter_cos(u) + 64'd16384) >> 15;
    mag = (v > 64'd32767) ? 16'd32767 : v[15:0];
    return (quad == 2'd1 || quad == 2'd2) ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

### sv/gwp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the gait waveform player: the tick
// channel and the result channel. No dependencies.
interface gwp_in_if;
  logic               valid;
  logic               ready;
  logic               run_toggle;
  logic               gyro_valid;
  logic signed [15:0] gyro_x;

  modport source(output valid, run_toggle, gyro_valid, gyro_x, input ready);
  modport sink(input valid, run_toggle, gyro_valid, gyro_x, output ready);
endinterface

interface gwp_out_if;
  logic               valid;
  logic               ready;
  logic [8:0]         table_index;
  logic [11:0]        spine_q4;
  logic [15:0]        leg0_angle;
  logic [15:0]        leg1_angle;
  logic signed [15:0] rate_raw;
  logic signed [47:0] angle_accum;

  modport source(output valid, table_index, spine_q4, leg0_angle, leg1_angle,
                 rate_raw, angle_accum, input ready);
  modport sink(input valid, table_index, spine_q4, leg0_angle, leg1_angle,
               rate_raw, angle_accum, output ready);
endinterface

### sv/gwp_out_fifo.sv
`timescale 1ns / 1ps
// Result queue of the gait waveform player: a small register FIFO that
// decouples the pipeline from the receiver. Depends on gwp_pkg.
module gwp_out_fifo
  import gwp_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gwp_result_t    push_data,
  input  logic           pop_ready,
  output gwp_result_t    head,
  output gwp_fifo_stat_t stat
);

  gwp_result_t        mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               pop;

  assign stat.valid = (count != '0);
  assign stat.count = count;
  assign pop        = stat.valid && pop_ready;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/gait_waveform_player_unit.sv
`timescale 1ns / 1ps
// Top level of the gait waveform player: tick handling, gyro integration,
// cosine table and result pipeline. Depends on gwp_pkg, gwp_if, gwp_out_fifo.
//
// Each transfer on in_ch is one millisecond tick carrying the start/stop
// toggle and an optional gyro sample. While running, a non-toggle tick that
// reaches the update interval produces one result on out_ch; other ticks produce none.
// The user must write registers through cfg_write, cfg_index and cfg_data
// only while the block is idle; the block does not enforce this. An unknown index is ignored.
// A tick is taken in every cycle in which in_ch.ready is high. A result passes
// through the tick counters and gyro product, then the accumulator and cosine
// table read, then the spine multiply, then the spine sum and clamp, and
// then waits in an eight-entry queue before it leaves on out_ch.
// If the receiver stalls, in_ch.ready drops only once the queue plus results
// still in the pipeline would fill all eight entries.
// Reset restores the register defaults, stops the block, clears all counters
// and the gyro integral, and empties the queue.
module gait_waveform_player_unit
  import gwp_pkg::*;
#(
  parameter int SAMPLES = SAMPLES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  gwp_in_if.sink            in_ch,
  gwp_out_if.source         out_ch
);

  localparam int IW = $clog2(SAMPLES);

  logic [11:0] spine_mid;
  logic [10:0] spine_half;
  logic [7:0]  leg_step;
  logic [9:0]  step_ms;
  logic [7:0]  update_ms;

  logic               running;
  logic [9:0]         ms_in_step;
  logic [IW-1:0]      step_index;
  logic [7:0]         ms_since_update;
  logic [15:0]        gyro_age;
  logic signed [15:0] last_rate;
  logic signed [47:0] acc;

  logic               running_next;
  logic [9:0]         ms_in_step_next;
  logic [IW-1:0]      step_index_next;
  logic [7:0]         ms_since_update_next;
  logic [15:0]        gyro_age_next;
  logic signed [15:0] last_rate_next;
  logic               emit;
  logic               prod_take;

  logic               in_fire;
  logic [15:0]        age_inc;
  logic [9:0]         ms_inc;
  logic [IW:0]        step_plus;
  logic [7:0]         msu_inc;
  logic signed [32:0] prod_comb;

  logic               s1_v;
  logic [IW-1:0]      s1_idx;
  logic signed [15:0] s1_rate;
  logic               prod_v;
  logic signed [32:0] prod;

  logic signed [48:0] acc_sum;
  logic signed [47:0] acc_next;
  logic [IW:0]        s1_mirror;
  logic [IW:0]        s1_m;
  logic [23:0]        leg0_w;
  logic [23:0]        peak_w;

  logic signed [15:0] rom_tab [SAMPLES];

  logic               s2_v;
  logic [IW-1:0]      s2_idx;
  logic signed [15:0] s2_rate;
  logic signed [47:0] s2_acc;
  logic [15:0]        s2_leg0;
  logic [15:0]        s2_leg1;
  logic signed [15:0] rom_q;
  logic signed [27:0] hprod_comb;

  logic               s3_v;
  logic [IW-1:0]      s3_idx;
  logic signed [15:0] s3_rate;
  logic signed [47:0] s3_acc;
  logic [15:0]        s3_leg0;
  logic [15:0]        s3_leg1;
  logic signed [27:0] s3_hprod;

  logic signed [30:0] spine_t;
  logic signed [15:0] spine_raw;
  logic [11:0]        spine_sat;

  gwp_result_t        res;
  gwp_result_t        head;
  gwp_fifo_stat_t     fifo_stat;
  logic [FIFO_CW+1:0] pending;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      spine_mid  <= SPINE_MID_RST;
      spine_half <= SPINE_HALF_RST;
      leg_step   <= LEG_STEP_RST;
      step_ms    <= STEP_MS_RST;
      update_ms  <= UPDATE_MS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SPINE_MID:  spine_mid  <= cfg_data[11:0];
        CFG_SPINE_HALF: spine_half <= cfg_data[10:0];
        CFG_LEG_STEP:   leg_step   <= cfg_data[7:0];
        CFG_STEP_MS:    step_ms    <= cfg_data[9:0];
        CFG_UPDATE_MS:  update_ms  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Tick handling.
  assign pending = (FIFO_CW + 2)'(fifo_stat.count) + (FIFO_CW + 2)'(s1_v)
                 + (FIFO_CW + 2)'(s2_v) + (FIFO_CW + 2)'(s3_v);
  assign in_ch.ready = (pending < (FIFO_CW + 2)'(FIFO_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign age_inc   = (gyro_age == 16'hFFFF) ? gyro_age : gyro_age + 16'd1;
  assign ms_inc    = ms_in_step + 10'd1;
  assign step_plus = {1'b0, step_index} + (IW + 1)'(1);
  assign msu_inc   = ms_since_update + 8'd1;
  assign prod_comb = in_ch.gyro_x * $signed({1'b0, age_inc});

  always_comb begin
    running_next         = running;
    ms_in_step_next      = ms_in_step;
    step_index_next      = step_index;
    ms_since_update_next = ms_since_update;
    gyro_age_next        = age_inc;
    last_rate_next       = last_rate;
    emit                 = 1'b0;
    prod_take            = 1'b0;
    if (in_ch.run_toggle) begin
      running_next = !running;
      if (!running) begin
        ms_in_step_next      = '0;
        step_index_next      = '0;
        ms_since_update_next = '0;
      end
    end else if (running) begin
      if (ms_inc >= step_ms) begin
        ms_in_step_next = '0;
        step_index_next = (step_plus >= (IW + 1)'(SAMPLES)) ? '0 : step_plus[IW-1:0];
      end else begin
        ms_in_step_next = ms_inc;
      end
      if (in_ch.gyro_valid) begin
        prod_take      = 1'b1;
        last_rate_next = in_ch.gyro_x;
        gyro_age_next  = '0;
      end
      if (msu_inc >= update_ms) begin
        ms_since_update_next = '0;
        emit                 = 1'b1;
      end else begin
        ms_since_update_next = msu_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      ms_in_step      <= '0;
      step_index      <= '0;
      ms_since_update <= '0;
      gyro_age        <= '0;
      last_rate       <= '0;
      s1_v            <= 1'b0;
      prod_v          <= 1'b0;
    end else begin
      if (in_fire) begin
        running         <= running_next;
        ms_in_step      <= ms_in_step_next;
        step_index      <= step_index_next;
        ms_since_update <= ms_since_update_next;
        gyro_age        <= gyro_age_next;
        last_rate       <= last_rate_next;
      end
      s1_v   <= in_fire && emit;
      prod_v <= in_fire && prod_take;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx  <= step_index_next;
    s1_rate <= last_rate_next;
    prod    <= prod_comb;
  end

  // Gyro integral, saturating at the 48-bit signed limits.
  assign acc_sum = {acc[47], acc} + 49'(prod);

  always_comb begin
    acc_next = acc;
    if (prod_v) begin
      if (acc_sum[48] != acc_sum[47]) begin
        acc_next = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
        acc_next = acc_sum[47:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  // Leg triangle and its complement.
  assign s1_mirror = (IW + 1)'(SAMPLES) - {1'b0, s1_idx};
  assign s1_m      = ({1'b0, s1_idx} < s1_mirror) ? {1'b0, s1_idx} : s1_mirror;
  assign leg0_w    = 24'(leg_step) * 24'(s1_m);
  assign peak_w    = (24'(leg_step) * 24'(SAMPLES)) >> 1;

  // Cosine table, one Q1.15 sample per table step.
  for (genvar g = 0; g < SAMPLES; g++) begin : g_rom
    localparam int unsigned QUAD = (4 * g) / SAMPLES;
    localparam int unsigned REM  = 4 * g - QUAD * SAMPLES;
    localparam logic [63:0] U    = (64'(REM) << 30) / SAMPLES;
    assign rom_tab[g] = cos_q15(U, 2'(QUAD));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    rom_q   <= rom_tab[s1_idx];
    s2_idx  <= s1_idx;
    s2_rate <= s1_rate;
    s2_acc  <= acc_next;
    s2_leg0 <= leg0_w[15:0];
    s2_leg1 <= peak_w[15:0] - leg0_w[15:0];
  end

  // Spine swing product.
  assign hprod_comb = $signed({1'b0, spine_half}) * rom_q;

  always_ff @(posedge clk) begin
    s3_idx   <= s2_idx;
    s3_rate  <= s2_rate;
    s3_acc   <= s2_acc;
    s3_leg0  <= s2_leg0;
    s3_leg1  <= s2_leg1;
    s3_hprod <= hprod_comb;
  end

  // Spine sum with rounding, offset and clamp to the actuator range.
  assign spine_t   = $signed({4'd0, spine_mid, 15'd0}) + 31'(s3_hprod)
                   + 31'sd16384 + 31'sd134217728;
  assign spine_raw = $signed(spine_t[30:15]) - 16'sd4096;

  always_comb begin
    if (spine_raw < 0) begin
      spine_sat = '0;
    end else if (spine_raw > 16'sd4095) begin
      spine_sat = 12'd4095;
    end else begin
      spine_sat = spine_raw[11:0];
    end
  end

  assign res.table_index = 9'(s3_idx);
  assign res.spine_q4    = spine_sat;
  assign res.leg0_angle  = s3_leg0;
  assign res.leg1_angle  = s3_leg1;
  assign res.rate_raw    = s3_rate;
  assign res.angle_accum = s3_acc;

  gwp_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_v),
    .push_data (res),
    .pop_ready (out_ch.ready),
    .head      (head),
    .stat      (fifo_stat)
  );

  assign out_ch.valid       = fifo_stat.valid;
  assign out_ch.table_index = head.table_index;
  assign out_ch.spine_q4    = head.spine_q4;
  assign out_ch.leg0_angle  = head.leg0_angle;
  assign out_ch.leg1_angle  = head.leg1_angle;
  assign out_ch.rate_raw    = head.rate_raw;
  assign out_ch.angle_accum = head.angle_accum;

  // The queue never receives a result when it is full.
  a_queue_room : assert property (@(posedge clk) disable iff (rst)
    (s3_v && !(fifo_stat.valid && out_ch.ready)) |-> (fifo_stat.count < FIFO_CW'(FIFO_DEPTH)))
    else $error("result pushed into a full queue");

  // A toggle tick never produces a result or a gyro update.
  a_toggle_quiet : assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.run_toggle) |=> (!s1_v && !prod_v))
    else $error("toggle tick produced work");

  // A stopped block ignores ticks other than a start.
  a_stopped_quiet : assert property (@(posedge clk) disable iff (rst)
    (in_fire && !running && !in_ch.run_toggle) |=> (!s1_v && !prod_v && !running))
    else $error("stopped block produced work");

  // A start clears the time counters.
  a_start_clears : assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_ch.run_toggle && !running) |=>
      (running && step_index == '0 && ms_in_step == '0 && ms_since_update == '0))
    else $error("start did not clear the time counters");

endmodule

### verif/tb_gait_waveform_player_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for gait_waveform_player_unit: millisecond ticks are
// driven on the tick channel and every result frame is checked against a
// built-in predictor of the gait timing, cosine spine and gyro integral.
// Depends on gwp_pkg, gwp_if and the block itself.
module tb_gait_waveform_player_unit;
  import gwp_pkg::*;

  localparam int TABLE_LEN = SAMPLES_DEFAULT;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int SETTLE_LIMIT = 5000;
  localparam int PIPE_FLUSH = 10;
  localparam bit [63:0] Q30_UNIT = 64'd1073741824;
  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  gwp_in_if tick_if();
  gwp_out_if frame_if();

  gait_waveform_player_unit #(.SAMPLES(TABLE_LEN)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(tick_if),
    .out_ch(frame_if)
  );

  // Register copies and gait state of the predictor.
  bit [11:0] spine_mid;
  bit [10:0] spine_half;
  bit [7:0] leg_gain;
  bit [9:0] step_period;
  bit [7:0] update_period;
  bit gait_running;
  bit [9:0] ms_count;
  bit [8:0] table_pos;
  bit [7:0] update_count;
  bit [15:0] gyro_age;
  logic signed [15:0] held_rate;
  logic signed [47:0] angle_sum;
  int cos_tab [0:TABLE_LEN-1];

  gwp_result_t expected_frames[$];
  gwp_result_t want, got;

  bit steady;
  int hold_left = 0;
  int fail_count;
  int frames_checked;
  int ticks_sent;
  int settings_used;
  longint cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic int unsigned draw_value(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) return lo;
    if (r < 4) return hi;
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic signed [15:0] draw_rate();
    if ($urandom_range(0, 9) != 0) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Cosine over a quarter wave, u in Q30 within [0, 1], by a Horner
  // polynomial in u squared; the result is clamped at zero.
  function automatic bit [63:0] quarter_wave(input bit [63:0] u);
    bit [63:0] coef [0:4];
    bit [63:0] u2;
    bit [63:0] acc;
    bit [63:0] p;
    coef = '{64'd1324675879, 64'd272375614, 64'd22401993, 64'd987048, 64'd27060};
    u2 = (u * u) >> 30;
    acc = coef[4];
    for (int k = 3; k >= 0; k--) acc = coef[k] - ((acc * u2) >> 30);
    p = (acc * u2) >> 30;
    return (p >= Q30_UNIT) ? 64'd0 : Q30_UNIT - p;
  endfunction

  function automatic int cos_sample(input int unsigned i);
    int unsigned quad;
    bit [63:0] rem;
    bit [63:0] u;
    bit [63:0] v;
    int mag;
    quad = (4 * i) / TABLE_LEN;
    rem = 64'(4 * i - quad * TABLE_LEN);
    u = (rem << 30) / TABLE_LEN;
    if (quad[0]) u = Q30_UNIT - u;
    v = (quarter_wave(u) + 64'd16384) >> 15;
    mag = (v > 64'd32767) ? 32767 : int'(v);
    return (quad == 1 || quad == 2) ? -mag : mag;
  endfunction

  // Advances the gait state by one accepted tick and queues the frame it
  // produces, if any.
  task automatic predict_gait_tick(input bit tog, input bit gv, input logic signed [15:0] gx);
    gwp_result_t r;
    int unsigned idx;
    int unsigned m;
    int unsigned leg0;
    int unsigned peak;
    longint t;
    longint sp;
    longint s;
    if (gyro_age != 16'hFFFF) gyro_age = gyro_age + 16'd1;
    if (tog) begin
      gait_running = !gait_running;
      if (gait_running) begin
        ms_count = '0;
        table_pos = '0;
        update_count = '0;
      end
      return;
    end
    if (!gait_running) return;
    ms_count = ms_count + 10'd1;
    if (ms_count >= step_period) begin
      ms_count = '0;
      table_pos = (int'(table_pos) + 1 >= TABLE_LEN) ? 9'd0 : table_pos + 9'd1;
    end
    if (gv) begin
      s = longint'(angle_sum) + longint'(gx) * longint'(gyro_age);
      if (s > ACC_HI) s = ACC_HI;
      if (s < ACC_LO) s = ACC_LO;
      angle_sum = s[47:0];
      held_rate = gx;
      gyro_age = '0;
    end
    update_count = update_count + 8'd1;
    if (update_count < update_period) return;
    update_count = '0;
    idx = 32'(table_pos);
    t = longint'(spine_mid) * 32768 + longint'(spine_half) * longint'(cos_tab[idx])
        + 16384 + 134217728;
    sp = (t >>> 15) - 4096;
    if (sp < 0) sp = 0;
    if (sp > 4095) sp = 4095;
    m = (idx < TABLE_LEN - idx) ? idx : TABLE_LEN - idx;
    leg0 = leg_gain * m;
    peak = (leg_gain * TABLE_LEN) >> 1;
    r.table_index = idx[8:0];
    r.spine_q4 = sp[11:0];
    r.leg0_angle = leg0[15:0];
    r.leg1_angle = 16'(peak - leg0);
    r.rate_raw = held_rate;
    r.angle_accum = angle_sum;
    expected_frames.push_back(r);
  endtask

  task automatic send_tick(input bit tog, input bit gv, input logic signed [15:0] gx);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      tick_if.valid <= 1'b0;
    end
    @(negedge clk);
    tick_if.valid <= 1'b1;
    tick_if.run_toggle <= tog;
    tick_if.gyro_valid <= gv;
    tick_if.gyro_x <= gx;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
    predict_gait_tick(tog, gv, gx);
    ticks_sent++;
  endtask

  // Stops sending, waits for every expected frame, then lets ticks that make
  // no frame leave the pipeline.
  task automatic settle();
    int waited;
    @(negedge clk);
    tick_if.valid <= 1'b0;
    waited = 0;
    while (expected_frames.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DW-1:0];
    @(posedge clk);
    case (idx)
      CFG_SPINE_MID:  spine_mid = val[11:0];
      CFG_SPINE_HALF: spine_half = val[10:0];
      CFG_LEG_STEP:   leg_gain = val[7:0];
      CFG_STEP_MS:    step_period = val[9:0];
      CFG_UPDATE_MS:  update_period = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_regs(input int unsigned mid, input int unsigned half,
                              input int unsigned leg, input int unsigned step,
                              input int unsigned upd);
    write_reg(CFG_SPINE_MID, mid);
    write_reg(CFG_SPINE_HALF, half);
    write_reg(CFG_LEG_STEP, leg);
    write_reg(CFG_STEP_MS, step);
    write_reg(CFG_UPDATE_MS, upd);
    settings_used++;
  endtask

  task automatic test_reset_values();
    send_tick(1'b1, 1'b0, '0);
    repeat (5) send_tick(1'b0, 1'($urandom_range(0, 1)), draw_rate());
    send_tick(1'b1, 1'b0, '0);
  endtask

  task automatic test_directed_cases();
    settle();
    // Largest values, with zero step and update periods.
    program_regs(4095, 2047, 255, 0, 0);
    for (int k = CFG_UPDATE_MS + 1; k < (1 << CFG_IW); k++) write_reg(CFG_IW'(k), 12'hFFF);
    send_tick(1'b1, 1'b1, 16'sh7FFF);
    send_tick(1'b0, 1'b1, 16'sh7FFF);
    send_tick(1'b0, 1'b1, 16'sh8000);
    send_tick(1'b0, 1'b0, 16'sh5A5A);
    send_tick(1'b0, 1'b1, 16'shFFFF);
    // Stopped ticks ignore the gyro; a restart clears the time counters.
    send_tick(1'b1, 1'b0, 16'sh0000);
    send_tick(1'b0, 1'b1, 16'sh1234);
    send_tick(1'b1, 1'b1, 16'sh4321);
    send_tick(1'b0, 1'b0, 16'sh0000);
    settle();
    program_regs(0, 2047, 0, 1000, 255);
    write_reg(CFG_STEP_MS, 12'hFFF);
    repeat (2) send_tick(1'b0, 1'b1, draw_rate());
    settle();
    // Periods lowered below the running counts while running.
    write_reg(CFG_STEP_MS, 1);
    write_reg(CFG_UPDATE_MS, 1);
    repeat (2) send_tick(1'b0, 1'b1, draw_rate());
  endtask

  task automatic test_table_sweep();
    settle();
    program_regs($urandom_range(0, 600), 2047, 255, 1, 1);
    if (!gait_running) send_tick(1'b1, 1'b0, '0);
    repeat (TABLE_LEN + 20) send_tick(1'b0, 1'($urandom_range(0, 1)), draw_rate());
  endtask

  task automatic test_random_phases();
    int ph;
    int active;
    int unsigned roll;
    bit tog;
    for (ph = 0; ph < 5; ph++) begin
      settle();
      steady = (ph == 0);
      program_regs(draw_value(0, 4095), draw_value(0, 2047), draw_value(0, 255),
                   ($urandom_range(0, 3) == 0) ? draw_value(1, 1000) : $urandom_range(1, 4),
                   ($urandom_range(0, 3) == 0) ? draw_value(1, 255) : $urandom_range(1, 6));
      if (!gait_running) send_tick(1'b1, 1'($urandom_range(0, 1)), draw_rate());
      active = 0;
      while (active < 70) begin
        roll = $urandom_range(0, 99);
        if (roll == 0) settle();
        tog = gait_running ? (roll >= 97) : (roll < 50);
        if (gait_running && !tog) active++;
        send_tick(tog, 1'($urandom_range(0, 1)), draw_rate());
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_gyro_long_gap();
    settle();
    steady = 1'b1;
    if (gait_running) send_tick(1'b1, 1'b0, '0);
    settle();
    program_regs(SPINE_MID_RST, SPINE_HALF_RST, LEG_STEP_RST, 1, 1);
    repeat (30) send_tick(1'b0, 1'($urandom_range(0, 1)), draw_rate());
    send_tick(1'b1, 1'b0, '0);
    send_tick(1'b0, 1'b1, 16'sh8000);
    repeat (3) send_tick(1'b0, 1'b0, draw_rate());
    send_tick(1'b0, 1'b1, 16'sh7FFF);
    steady = 1'b0;
  endtask

  // Result receiver with random stalls.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      frame_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      frame_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) hold_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && frame_if.valid && frame_if.ready) begin
      if (expected_frames.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Unexpected result frame: index %0d spine %0d",
                   frame_if.table_index, frame_if.spine_q4);
      end else begin
        want = expected_frames.pop_front();
        got.table_index = frame_if.table_index;
        got.spine_q4 = frame_if.spine_q4;
        got.leg0_angle = frame_if.leg0_angle;
        got.leg1_angle = frame_if.leg1_angle;
        got.rate_raw = frame_if.rate_raw;
        got.angle_accum = frame_if.angle_accum;
        if (got.table_index !== want.table_index || got.spine_q4 !== want.spine_q4 ||
            got.leg0_angle !== want.leg0_angle || got.leg1_angle !== want.leg1_angle ||
            got.rate_raw !== want.rate_raw || got.angle_accum !== want.angle_accum) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Frame %0d mismatch, expected: index %0d spine %0d legs %0d %0d rate %0d acc %0d",
                     frames_checked, want.table_index, want.spine_q4, want.leg0_angle,
                     want.leg1_angle, want.rate_raw, want.angle_accum);
            $display("  actual: index %0d spine %0d legs %0d %0d rate %0d acc %0d",
                     got.table_index, got.spine_q4, got.leg0_angle, got.leg1_angle,
                     got.rate_raw, got.angle_accum);
          end
        end
        frames_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped at the cycle limit with %0d frames outstanding",
             expected_frames.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tick_if.valid = 1'b0;
    tick_if.run_toggle = 1'b0;
    tick_if.gyro_valid = 1'b0;
    tick_if.gyro_x = '0;
    steady = 1'b0;
    fail_count = 0;
    frames_checked = 0;
    ticks_sent = 0;
    settings_used = 0;

    spine_mid = SPINE_MID_RST;
    spine_half = SPINE_HALF_RST;
    leg_gain = LEG_STEP_RST;
    step_period = STEP_MS_RST;
    update_period = UPDATE_MS_RST;
    gait_running = 1'b0;
    ms_count = '0;
    table_pos = '0;
    update_count = '0;
    gyro_age = '0;
    held_rate = '0;
    angle_sum = '0;
    for (int i = 0; i < TABLE_LEN; i++) cos_tab[i] = cos_sample(i);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_directed_cases();
    test_table_sweep();
    test_random_phases();
    test_gyro_long_gap();
    settle();

    if (expected_frames.size() != 0) begin
      fail_count += expected_frames.size();
      $display("%0d expected frames never arrived", expected_frames.size());
    end
    $display("Sent %0d ticks under %0d register settings and checked %0d result frames,",
             ticks_sent, settings_used, frames_checked);
    $display("including a full table sweep and a long gap between gyro samples.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
